// ===== rtl/bpfm_pkg.sv =====
// shared types and constants for the buffer pool frame manager
package bpfm_pkg;

    localparam int POOL_FRAMES_DEF = 16;
    localparam int PIN_BITS_DEF    = 8;
    localparam int PAGE_W          = 31;
    localparam int CFG_DATA_W      = 5;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INST_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INST_NUMBER = 1'd1;

    typedef enum logic [2:0] {
        MODE_NEW       = 3'd0,
        MODE_FETCH     = 3'd1,
        MODE_UNPIN     = 3'd2,
        MODE_DELETE    = 3'd3,
        MODE_FLUSH     = 3'd4,
        MODE_FLUSH_ALL = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_VICTIM,
        ST_LRU_FIX,
        ST_APPLY,
        ST_FLUSH_ALL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [PAGE_W-1:0] page_number;
        logic              mark_dirty;
    } req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] result_page;
        logic [5:0]        frame_index;
        logic              success;
        logic              last;
    } rsp_t;

endpackage

// ===== rtl/bpfm_if.sv =====
// valid/ready channel interface carrying one item
interface bpfm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bpfm_out_fifo.sv =====
// small result queue between the sequencer and the output channel
module bpfm_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpfm_pkg::rsp_t push_data,
    output logic          empty_all,
    output logic          has_room,
    bpfm_if.source        res
);
    import bpfm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rsp_t             mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             pop;

    assign pop       = res.valid && res.ready;
    assign res.valid = (cnt_reg != '0);
    assign res.data  = mem_reg[rd_reg];
    assign empty_all = (cnt_reg == '0);
    assign has_room  = (cnt_reg < (AW+1)'(DEPTH - 1));

    always_comb
    begin
        wr_next  = push ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end
endmodule

// ===== rtl/buffer_pool_frame_manager.sv =====
// buffer pool frame manager: frame metadata, free queue, lru order, page allocator
//
//  channel   dir  payload                                         handshake
//  req       in   mode, page_number, mark_dirty                   valid/ready
//  res       out  kind, result_page, frame_index, success, last   valid/ready
//  cfg       in   cfg_we, cfg_index, cfg_data                     write enable
//
// one request walks all frames once with a shared compare unit, then passes a decide
// state and an update state, then walks the frames again to renumber lru ranks (flush
// all walks them instead to queue its write-backs), then emits 1 to 3 items, one per
// cycle while the result queue has room.
// reset empties all frames and fills the free queue; a result queue holding three items
// stalls the flush walk and emission, and req ready stays low until every result has left.
module buffer_pool_frame_manager #(
    parameter int POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
    parameter int PIN_BITS    = bpfm_pkg::PIN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpfm_pkg::CFG_DATA_W-1:0] cfg_data,
    bpfm_if.sink                          req,
    bpfm_if.source                        res
);
    import bpfm_pkg::*;

    localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    // frame metadata
    logic [PAGE_W-1:0]   page_reg  [POOL_FRAMES];
    logic [POOL_FRAMES-1:0] valid_reg, dirty_reg;
    logic [PIN_BITS-1:0] pins_reg  [POOL_FRAMES];
    logic [CW-1:0]       age_reg   [POOL_FRAMES];
    logic [FW-1:0]       fq_reg    [POOL_FRAMES];
    logic [FW-1:0]       fhead_reg;
    logic [CW-1:0]       fcount_reg, lcount_reg;
    logic [PAGE_W-1:0]   next_page_reg;
    logic [4:0]          icount_reg;

    state_t              state_reg, state_next;
    req_t                r_reg;
    logic [FW-1:0]       idx_reg;
    logic                hit_reg, anyfree_reg;
    logic [FW-1:0]       hit_f_reg;
    logic                vic_ok_reg;
    logic [FW-1:0]       vic_reg;
    logic [CW-1:0]       rm_rank_reg;     // rank being removed during the fix walk
    logic [FW-1:0]       tgt_reg;
    logic                ok_reg;
    logic                wb_reg, rd_reg_flag;
    logic [PAGE_W-1:0]   wb_page_reg, st_page_reg;
    logic [1:0]          emit_step_reg;

    logic                push;
    rsp_t                push_data;
    logic                fifo_empty, fifo_room;
    logic                last_idx;
    logic [CW:0]         fq_sum;
    logic [FW-1:0]       fq_tail;

    assign last_idx  = (idx_reg == FW'(POOL_FRAMES-1));
    assign req.ready = (state_reg == ST_IDLE) && fifo_empty;

    // slot behind the last free frame, wrapped without a divider
    assign fq_sum  = (CW+1)'(fhead_reg) + (CW+1)'(fcount_reg);
    assign fq_tail = (fq_sum >= (CW+1)'(POOL_FRAMES)) ?
                     FW'(fq_sum - (CW+1)'(POOL_FRAMES)) : FW'(fq_sum);

    bpfm_out_fifo #(.DEPTH(4)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .empty_all (fifo_empty),
        .has_room  (fifo_room),
        .res       (res)
    );

    // next state and result emission
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        push_data  = '0;
        unique case (state_reg)
            ST_IDLE:
                if (req.valid && req.ready)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (last_idx)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = ST_APPLY;
            ST_VICTIM:
                state_next = ST_APPLY;
            ST_LRU_FIX:
                if (last_idx)
                    state_next = ST_EMIT;
            ST_APPLY:
                state_next = (r_reg.mode == MODE_FLUSH_ALL) ? ST_FLUSH_ALL : ST_LRU_FIX;
            ST_FLUSH_ALL:
            begin
                if (fifo_room)
                begin
                    if (valid_reg[idx_reg])
                    begin
                        push                  = 1'b1;
                        push_data.kind        = KIND_WRITE;
                        push_data.result_page = page_reg[idx_reg];
                        push_data.frame_index = 6'(idx_reg);
                    end
                    if (last_idx)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (fifo_room)
                begin
                    push = 1'b1;
                    push_data.frame_index = 6'(tgt_reg);
                    if (emit_step_reg == 2'd0 && wb_reg)
                    begin
                        push_data.kind        = KIND_WRITE;
                        push_data.result_page = wb_page_reg;
                    end
                    else if (emit_step_reg != 2'd2 && rd_reg_flag)
                    begin
                        push_data.kind        = KIND_READ;
                        push_data.result_page = st_page_reg;
                    end
                    else
                    begin
                        push_data.kind        = KIND_STATUS;
                        push_data.result_page = st_page_reg;
                        push_data.success     = ok_reg;
                        push_data.last        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            fhead_reg     <= '0;
            fcount_reg    <= CW'(POOL_FRAMES);
            lcount_reg    <= '0;
            icount_reg    <= 5'd1;
            next_page_reg <= '0;
            idx_reg       <= '0;
            emit_step_reg <= '0;
            r_reg         <= '0;
            hit_reg       <= 1'b0;
            hit_f_reg     <= '0;
            anyfree_reg   <= 1'b0;
            vic_ok_reg    <= 1'b0;
            vic_reg       <= '0;
            rm_rank_reg   <= '0;
            tgt_reg       <= '0;
            ok_reg        <= 1'b0;
            wb_reg        <= 1'b0;
            rd_reg_flag   <= 1'b0;
            wb_page_reg   <= '0;
            st_page_reg   <= '0;
            for (int i = 0; i < POOL_FRAMES; i++)
            begin
                page_reg[i] <= '0;
                pins_reg[i] <= '0;
                age_reg[i]  <= '0;
                fq_reg[i]   <= FW'(i);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_INST_COUNT)
                    icount_reg <= cfg_data;
                else
                    next_page_reg <= PAGE_W'(cfg_data[3:0]);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    r_reg         <= req.data;
                    idx_reg       <= '0;
                    hit_reg       <= 1'b0;
                    hit_f_reg     <= '0;
                    anyfree_reg   <= 1'b0;
                    vic_ok_reg    <= 1'b0;
                    vic_reg       <= '0;
                    wb_reg        <= 1'b0;
                    rd_reg_flag   <= 1'b0;
                    rm_rank_reg   <= '0;
                    emit_step_reg <= '0;
                end
                ST_SCAN:
                begin
                    // shared compare: one frame per cycle
                    if (!hit_reg && valid_reg[idx_reg] && page_reg[idx_reg] == r_reg.page_number)
                    begin
                        hit_reg   <= 1'b1;
                        hit_f_reg <= idx_reg;
                    end
                    if (pins_reg[idx_reg] == '0)
                        anyfree_reg <= 1'b1;
                    if (age_reg[idx_reg] == CW'(1) && !vic_ok_reg)
                    begin
                        vic_ok_reg <= 1'b1;
                        vic_reg    <= idx_reg;
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
                ST_DECIDE:
                begin
                    // hit_f_reg stays zero on a miss, which is the frame a miss reports unless it takes a frame
                    case (r_reg.mode)
                        MODE_NEW:
                        begin
                            tgt_reg <= '0;
                            if (anyfree_reg && (fcount_reg != '0 || vic_ok_reg))
                            begin
                                ok_reg        <= 1'b1;
                                st_page_reg   <= next_page_reg;
                                next_page_reg <= next_page_reg + PAGE_W'(icount_reg);
                            end
                            else
                            begin
                                ok_reg      <= 1'b0;
                                st_page_reg <= '0;
                            end
                        end
                        MODE_FETCH:
                        begin
                            st_page_reg <= r_reg.page_number;
                            tgt_reg     <= hit_f_reg;
                            if (hit_reg)
                                ok_reg <= (pins_reg[hit_f_reg] != PIN_MAX);
                            else
                            begin
                                ok_reg      <= (fcount_reg != '0 || vic_ok_reg);
                                rd_reg_flag <= (fcount_reg != '0 || vic_ok_reg);
                            end
                        end
                        MODE_UNPIN:
                        begin
                            st_page_reg <= r_reg.page_number;
                            tgt_reg     <= hit_f_reg;
                            ok_reg      <= hit_reg && (pins_reg[hit_f_reg] != '0);
                        end
                        MODE_DELETE:
                        begin
                            st_page_reg <= r_reg.page_number;
                            tgt_reg     <= hit_f_reg;
                            ok_reg      <= !hit_reg || (pins_reg[hit_f_reg] == '0);
                        end
                        MODE_FLUSH:
                        begin
                            st_page_reg <= r_reg.page_number;
                            tgt_reg     <= hit_f_reg;
                            ok_reg      <= hit_reg;
                        end
                        MODE_FLUSH_ALL:
                        begin
                            st_page_reg <= '0;
                            tgt_reg     <= '0;
                            ok_reg      <= 1'b1;
                        end
                        default:
                        begin
                            st_page_reg <= '0;
                            tgt_reg     <= '0;
                            ok_reg      <= 1'b0;
                        end
                    endcase
                end
                ST_APPLY:
                begin
                    idx_reg <= '0;
                    if (ok_reg)
                    begin
                        case (r_reg.mode) inside
                            MODE_NEW, MODE_FETCH:
                                if (r_reg.mode == MODE_FETCH && hit_reg)
                                begin
                                    pins_reg[hit_f_reg] <= pins_reg[hit_f_reg] + 1'b1;
                                    rm_rank_reg         <= age_reg[hit_f_reg];
                                    age_reg[hit_f_reg]  <= '0;
                                    if (age_reg[hit_f_reg] != '0)
                                        lcount_reg <= lcount_reg - 1'b1;
                                end
                                else
                                begin
                                    // take a frame: free queue head, else lru victim
                                    if (fcount_reg != '0)
                                    begin
                                        tgt_reg    <= fq_reg[fhead_reg];
                                        fhead_reg  <= (fhead_reg == FW'(POOL_FRAMES-1)) ?
                                                      '0 : fhead_reg + 1'b1;
                                        fcount_reg <= fcount_reg - 1'b1;
                                        page_reg[fq_reg[fhead_reg]]  <= st_page_reg;
                                        valid_reg[fq_reg[fhead_reg]] <= 1'b1;
                                        pins_reg[fq_reg[fhead_reg]]  <= PIN_BITS'(1);
                                        dirty_reg[fq_reg[fhead_reg]] <= 1'b0;
                                        rm_rank_reg <= age_reg[fq_reg[fhead_reg]];
                                        age_reg[fq_reg[fhead_reg]] <= '0;
                                        if (age_reg[fq_reg[fhead_reg]] != '0)
                                            lcount_reg <= lcount_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        tgt_reg     <= vic_reg;
                                        wb_reg      <= valid_reg[vic_reg] && dirty_reg[vic_reg];
                                        wb_page_reg <= page_reg[vic_reg];
                                        page_reg[vic_reg]  <= st_page_reg;
                                        valid_reg[vic_reg] <= 1'b1;
                                        pins_reg[vic_reg]  <= PIN_BITS'(1);
                                        dirty_reg[vic_reg] <= 1'b0;
                                        rm_rank_reg        <= CW'(1);
                                        age_reg[vic_reg]   <= '0;
                                        lcount_reg         <= lcount_reg - 1'b1;
                                    end
                                end
                            MODE_UNPIN:
                            begin
                                pins_reg[tgt_reg] <= pins_reg[tgt_reg] - 1'b1;
                                if (r_reg.mark_dirty)
                                    dirty_reg[tgt_reg] <= 1'b1;
                                if (pins_reg[tgt_reg] == PIN_BITS'(1) && age_reg[tgt_reg] == '0)
                                begin
                                    age_reg[tgt_reg] <= lcount_reg + 1'b1;
                                    lcount_reg       <= lcount_reg + 1'b1;
                                end
                            end
                            MODE_DELETE:
                                if (hit_reg)
                                begin
                                    wb_reg      <= dirty_reg[tgt_reg];
                                    wb_page_reg <= page_reg[tgt_reg];
                                    rm_rank_reg <= age_reg[tgt_reg];
                                    age_reg[tgt_reg] <= '0;
                                    if (age_reg[tgt_reg] != '0)
                                        lcount_reg <= lcount_reg - 1'b1;
                                    valid_reg[tgt_reg] <= 1'b0;
                                    dirty_reg[tgt_reg] <= 1'b0;
                                    pins_reg[tgt_reg]  <= '0;
                                    page_reg[tgt_reg]  <= '0;
                                    if (fcount_reg < CW'(POOL_FRAMES))
                                    begin
                                        fq_reg[fq_tail] <= tgt_reg;
                                        fcount_reg      <= fcount_reg + 1'b1;
                                    end
                                end
                            MODE_FLUSH:
                            begin
                                wb_reg             <= 1'b1;
                                wb_page_reg        <= r_reg.page_number;
                                dirty_reg[tgt_reg] <= 1'b0;
                            end
                            default:
                                ;
                        endcase
                    end
                end
                ST_LRU_FIX:
                begin
                    // close the gap left by a removed rank, one frame per cycle
                    if (rm_rank_reg != '0 && age_reg[idx_reg] > rm_rank_reg)
                        age_reg[idx_reg] <= age_reg[idx_reg] - 1'b1;
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
                ST_FLUSH_ALL:
                    if (fifo_room)
                    begin
                        dirty_reg[idx_reg] <= 1'b0;
                        idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                    end
                ST_EMIT:
                    if (fifo_room)
                    begin
                        if (emit_step_reg == 2'd0 && wb_reg)
                            emit_step_reg <= 2'd1;
                        else
                            emit_step_reg <= 2'd2;
                    end
                default:
                    ;
            endcase
        end
    end

    // free count never exceeds the pool size
    a_fcount: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= CW'(POOL_FRAMES)) else $error("free count overflow");

    // a taken request, accepted only when idle with all results drained, starts the scan
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN)) else $error("accept lost");

    // every status push ends the request
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |=> (state_reg == ST_IDLE)) else $error("status not final");

    // lru members never outnumber the frames
    a_lcount: assert property (@(posedge clk) disable iff (!rst_n)
        lcount_reg <= CW'(POOL_FRAMES)) else $error("lru count overflow");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the buffer pool frame manager
module testbench;
    import bpfm_pkg::*;

    localparam int FRAMES      = POOL_FRAMES_DEF;
    localparam int PIN_LIMIT   = (1 << PIN_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 2 * FRAMES + 40;
    localparam int EXP_DEPTH   = 64;
    localparam int DIR_ROWS    = 22;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [PAGE_W-1:0] PAGE_TOP = {PAGE_W{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpfm_if #(.T(req_t)) req_ch ();
    bpfm_if #(.T(rsp_t)) res_ch ();

    buffer_pool_frame_manager u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .res(res_ch)
    );

    // predicted pool state
    logic [PAGE_W-1:0] pool_page [FRAMES];
    logic              pool_valid [FRAMES];
    logic [PIN_BITS_DEF-1:0] pool_pins [FRAMES];
    logic              pool_dirty [FRAMES];
    int                free_fifo [FRAMES];
    int                free_head;
    int                free_cnt;
    int                lru_rank [FRAMES];
    int                lru_cnt;
    logic [PAGE_W-1:0] alloc_next;
    logic [4:0]        step_cfg;

    // expected items, written and read through running counters
    rsp_t exp_buf [EXP_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    int   fail_count = 0;
    int   cycle_count = 0;
    int   long_stall_req;

    typedef struct {
        logic [2:0]        mode;
        logic [PAGE_W-1:0] page;
        logic              dirty;
        bit                typed;
        logic [PAGE_W-1:0] exp_page;
        logic [5:0]        exp_frame;
        logic              exp_ok;
    } dir_row_t;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void push_rsp(logic [1:0] k, logic [PAGE_W-1:0] p, int f,
                                     logic ok, logic lst);
        rsp_t r;
        r.kind = k;
        r.result_page = p;
        r.frame_index = 6'(f);
        r.success = ok;
        r.last = lst;
        exp_buf[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic void pool_reset();
        for (int f = 0; f < FRAMES; f++)
        begin
            pool_page[f] = '0;
            pool_valid[f] = 1'b0;
            pool_pins[f] = '0;
            pool_dirty[f] = 1'b0;
            free_fifo[f] = f;
            lru_rank[f] = 0;
        end
        free_head = 0;
        free_cnt = FRAMES;
        lru_cnt = 0;
        step_cfg = 5'd1;
        alloc_next = '0;
    endfunction

    function automatic int find_frame(logic [PAGE_W-1:0] p);
        for (int f = 0; f < FRAMES; f++)
            if (pool_valid[f] && pool_page[f] == p)
                return f;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        int r;
        r = lru_rank[f];
        if (r == 0)
            return;
        for (int g = 0; g < FRAMES; g++)
            if (lru_rank[g] > r)
                lru_rank[g]--;
        lru_rank[f] = 0;
        lru_cnt--;
    endfunction

    // free queue first, else least recently unpinned frame, with write-back if dirty
    function automatic int claim_frame();
        int f;
        if (free_cnt > 0)
        begin
            f = free_fifo[free_head];
            free_head = (free_head + 1) % FRAMES;
            free_cnt--;
            return f;
        end
        for (int g = 0; g < FRAMES; g++)
            if (lru_rank[g] == 1)
            begin
                lru_drop(g);
                if (pool_valid[g] && pool_dirty[g])
                    push_rsp(KIND_WRITE, pool_page[g], g, 1'b0, 1'b0);
                pool_valid[g] = 1'b0;
                return g;
            end
        return -1;
    endfunction

    function automatic void load_frame(int f, logic [PAGE_W-1:0] p);
        pool_page[f] = p;
        pool_valid[f] = 1'b1;
        pool_pins[f] = PIN_BITS_DEF'(1);
        pool_dirty[f] = 1'b0;
        lru_drop(f);
    endfunction

    function automatic void predict_frame_request(req_t rq);
        int f;
        bit any_unpinned;
        logic [PAGE_W-1:0] id;
        logic [PAGE_W-1:0] p;
        p = rq.page_number;
        case (rq.mode)
            MODE_NEW:
            begin
                any_unpinned = 0;
                for (int g = 0; g < FRAMES; g++)
                    if (pool_pins[g] == 0)
                        any_unpinned = 1;
                f = any_unpinned ? claim_frame() : -1;
                if (f < 0)
                    push_rsp(KIND_STATUS, '0, 0, 1'b0, 1'b1);
                else
                begin
                    id = alloc_next;
                    alloc_next = alloc_next + PAGE_W'(step_cfg);
                    load_frame(f, id);
                    push_rsp(KIND_STATUS, id, f, 1'b1, 1'b1);
                end
            end
            MODE_FETCH:
            begin
                f = find_frame(p);
                if (f >= 0)
                begin
                    if (pool_pins[f] >= PIN_LIMIT)
                        push_rsp(KIND_STATUS, p, f, 1'b0, 1'b1);
                    else
                    begin
                        pool_pins[f]++;
                        lru_drop(f);
                        push_rsp(KIND_STATUS, p, f, 1'b1, 1'b1);
                    end
                end
                else
                begin
                    f = claim_frame();
                    if (f < 0)
                        push_rsp(KIND_STATUS, p, 0, 1'b0, 1'b1);
                    else
                    begin
                        load_frame(f, p);
                        push_rsp(KIND_READ, p, f, 1'b0, 1'b0);
                        push_rsp(KIND_STATUS, p, f, 1'b1, 1'b1);
                    end
                end
            end
            MODE_UNPIN:
            begin
                f = find_frame(p);
                if (f < 0)
                    push_rsp(KIND_STATUS, p, 0, 1'b0, 1'b1);
                else if (pool_pins[f] == 0)
                    push_rsp(KIND_STATUS, p, f, 1'b0, 1'b1);
                else
                begin
                    pool_pins[f]--;
                    if (rq.mark_dirty)
                        pool_dirty[f] = 1'b1;
                    if (pool_pins[f] == 0 && lru_rank[f] == 0)
                    begin
                        lru_cnt++;
                        lru_rank[f] = lru_cnt;
                    end
                    push_rsp(KIND_STATUS, p, f, 1'b1, 1'b1);
                end
            end
            MODE_DELETE:
            begin
                f = find_frame(p);
                if (f < 0)
                    push_rsp(KIND_STATUS, p, 0, 1'b1, 1'b1);
                else if (pool_pins[f] > 0)
                    push_rsp(KIND_STATUS, p, f, 1'b0, 1'b1);
                else
                begin
                    if (pool_dirty[f])
                        push_rsp(KIND_WRITE, pool_page[f], f, 1'b0, 1'b0);
                    lru_drop(f);
                    pool_valid[f] = 1'b0;
                    pool_dirty[f] = 1'b0;
                    pool_pins[f] = '0;
                    pool_page[f] = '0;
                    if (free_cnt < FRAMES)
                    begin
                        free_fifo[(free_head + free_cnt) % FRAMES] = f;
                        free_cnt++;
                    end
                    push_rsp(KIND_STATUS, p, f, 1'b1, 1'b1);
                end
            end
            MODE_FLUSH:
            begin
                f = find_frame(p);
                if (f < 0)
                    push_rsp(KIND_STATUS, p, 0, 1'b0, 1'b1);
                else
                begin
                    push_rsp(KIND_WRITE, p, f, 1'b0, 1'b0);
                    pool_dirty[f] = 1'b0;
                    push_rsp(KIND_STATUS, p, f, 1'b1, 1'b1);
                end
            end
            MODE_FLUSH_ALL:
            begin
                for (int g = 0; g < FRAMES; g++)
                    if (pool_valid[g])
                    begin
                        push_rsp(KIND_WRITE, pool_page[g], g, 1'b0, 1'b0);
                        pool_dirty[g] = 1'b0;
                    end
                push_rsp(KIND_STATUS, '0, 0, 1'b1, 1'b1);
            end
            default:
                push_rsp(KIND_STATUS, '0, 0, 1'b0, 1'b1);
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (exp_rd == exp_wr)
            begin
                $error("unexpected result item kind=%0d page=%0d", got.kind, got.result_page);
                fail_count++;
            end
            else
            begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.result_page !== want.result_page)
                begin
                    $error("result_page: expected %0d, got %0d",
                           want.result_page, got.result_page);
                    fail_count++;
                end
                if (got.frame_index !== want.frame_index)
                begin
                    $error("frame_index: expected %0d, got %0d",
                           want.frame_index, got.frame_index);
                    fail_count++;
                end
                if (got.success !== want.success)
                begin
                    $error("success: expected %0d, got %0d", want.success, got.success);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off on request
    always @(negedge clk)
    begin
        int hold;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (long_stall_req)
        begin
            long_stall_req = 0;
            res_ch.ready <= 1'b0;
            for (hold = 0; hold < 400; hold++)
                @(negedge clk);
            res_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(5, 25)) @(negedge clk);
            res_ch.ready <= 1'b1;
        end
        else
            res_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(logic [2:0] m, logic [PAGE_W-1:0] p, logic d, bit gaps);
        req_t rq;
        int gap;
        rq.mode = m;
        rq.page_number = p;
        rq.mark_dirty = d;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_frame_request(rq);
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INST_COUNT)
            step_cfg = val;
        else
            alloc_next = PAGE_W'(val[3:0]);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(bit want_pinned);
        int f;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            for (int tries = 0; tries < 24; tries++)
            begin
                f = $urandom_range(0, FRAMES - 1);
                if (pool_valid[f] && (!want_pinned || pool_pins[f] != 0))
                    return pool_page[f];
            end
        if (r < 8)
            return PAGE_W'($urandom_range(0, 40));
        return PAGE_W'($urandom());
    endfunction

    task automatic random_items(int n);
        logic [2:0] m;
        int w;
        for (int i = 0; i < n; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 20)
                m = MODE_NEW;
            else if (w < 45)
                m = MODE_FETCH;
            else if (w < 75)
                m = MODE_UNPIN;
            else if (w < 85)
                m = MODE_DELETE;
            else if (w < 93)
                m = MODE_FLUSH;
            else if (w < 97)
                m = MODE_FLUSH_ALL;
            else
                m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
            send_item(m, pick_page(m == MODE_UNPIN), 1'($urandom()), 1);
        end
    endtask

    // pin every frame, try one more allocation, then release them all
    task automatic fill_and_release();
        logic [PAGE_W-1:0] pg;
        for (int i = 0; i <= FRAMES; i++)
            send_item(MODE_NEW, '0, 1'b0, 0);
        for (int f = 0; f < FRAMES; f++)
        begin
            pg = pool_page[f];
            // a duplicate id in a lower frame would take the unpin instead
            while (pool_valid[f] && pool_page[f] == pg && pool_pins[f] != 0 &&
                   find_frame(pg) == f)
                send_item(MODE_UNPIN, pg, 1'($urandom()), 0);
        end
    endtask

    initial
    begin
        dir_row_t rows [DIR_ROWS];
        int typed_len;
        rsp_t tail;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        long_stall_req = 0;
        pool_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3 * FRAMES) @(posedge clk);

        rows = '{
            '{MODE_FLUSH_ALL, '0, 1'b0, 1, '0, 6'd0, 1'b1},
            '{MODE_UNPIN, 31'd5, 1'b1, 1, 31'd5, 6'd0, 1'b0},
            '{MODE_DELETE, 31'd7, 1'b0, 1, 31'd7, 6'd0, 1'b1},
            '{MODE_FLUSH, PAGE_TOP, 1'b0, 1, PAGE_TOP, 6'd0, 1'b0},
            '{MODE_SPARE_A, 31'd3, 1'b0, 1, '0, 6'd0, 1'b0},
            '{MODE_SPARE_B, PAGE_TOP, 1'b1, 1, '0, 6'd0, 1'b0},
            '{MODE_NEW, '0, 1'b0, 1, 31'd0, 6'd0, 1'b1},
            '{MODE_NEW, '0, 1'b1, 1, 31'd1, 6'd1, 1'b1},
            '{MODE_FETCH, 31'd0, 1'b0, 1, 31'd0, 6'd0, 1'b1},
            '{MODE_FETCH, PAGE_TOP, 1'b0, 0, '0, 6'd0, 1'b0},
            '{MODE_UNPIN, 31'd0, 1'b1, 1, 31'd0, 6'd0, 1'b1},
            '{MODE_UNPIN, 31'd0, 1'b0, 1, 31'd0, 6'd0, 1'b1},
            '{MODE_UNPIN, 31'd0, 1'b0, 1, 31'd0, 6'd0, 1'b0},
            '{MODE_FLUSH, 31'd0, 1'b0, 0, '0, 6'd0, 1'b0},
            '{MODE_DELETE, 31'd1, 1'b0, 1, 31'd1, 6'd1, 1'b0},
            '{MODE_UNPIN, 31'd1, 1'b1, 0, '0, 6'd0, 1'b0},
            '{MODE_DELETE, 31'd1, 1'b0, 0, '0, 6'd0, 1'b0},
            '{MODE_FLUSH_ALL, '0, 1'b0, 0, '0, 6'd0, 1'b0},
            '{MODE_UNPIN, PAGE_TOP, 1'b1, 0, '0, 6'd0, 1'b0},
            '{MODE_FETCH, 31'h2AAAAAAA, 1'b0, 0, '0, 6'd0, 1'b0},
            '{MODE_UNPIN, 31'h2AAAAAAA, 1'b1, 0, '0, 6'd0, 1'b0},
            '{MODE_DELETE, 31'd0, 1'b0, 0, '0, 6'd0, 1'b0}
        };
        foreach (rows[i])
        begin
            typed_len = exp_wr;
            send_item(rows[i].mode, rows[i].page, rows[i].dirty, 1);
            tail = exp_buf[(exp_wr - 1) % EXP_DEPTH];
            if (rows[i].typed && (exp_wr != typed_len + 1 ||
                tail.result_page !== rows[i].exp_page ||
                tail.frame_index !== rows[i].exp_frame || tail.success !== rows[i].exp_ok))
            begin
                $error("directed row %0d: status expected page=%0d frame=%0d ok=%0d",
                       i, rows[i].exp_page, rows[i].exp_frame, rows[i].exp_ok);
                fail_count++;
            end
        end
        drain();

        // receiver holds off while requests keep coming
        long_stall_req = 1;
        fill_and_release();
        random_items(28);
        drain();

        write_reg(REG_INST_COUNT, 5'd16);
        write_reg(REG_INST_NUMBER, 5'd15);
        random_items(28);
        fill_and_release();
        drain();

        // zero step hands out the same id repeatedly
        write_reg(REG_INST_COUNT, 5'd0);
        write_reg(REG_INST_NUMBER, 5'd7);
        random_items(28);
        drain();

        write_reg(REG_INST_COUNT, 5'd3);
        write_reg(REG_INST_NUMBER, 5'd5);
        random_items(28);
        drain();

        write_reg(REG_INST_COUNT, 5'd1);
        write_reg(REG_INST_NUMBER, 5'd0);
        random_items(28);
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== buffer_pool_frame_manager.f =====
rtl/bpfm_pkg.sv
rtl/bpfm_if.sv
rtl/bpfm_out_fifo.sv
rtl/buffer_pool_frame_manager.sv
dv/testbench.sv
